// ===== rtl/chit_pkg.sv =====
package chit_pkg;

    localparam int DEF_MAX_ENTRIES    = 1024;
    localparam int DEF_MAX_HEAD_SLOTS = 2048;
    localparam logic [11:0] TABLE_LENGTH_RST = 12'd1536;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [1:0] {
        KIND_CLEAR,
        KIND_INSERT,
        KIND_FIND,
        KIND_NOP
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] key_hash;
        logic [31:0] key_fingerprint;
        logic [31:0] entry_value;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_value;
    } res_t;

endpackage

// ===== rtl/chit_fifo.sv =====
module chit_fifo
    import chit_pkg::*;
#(
    parameter type T = logic
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  T     wdata,
    output logic full,
    input  logic pop,
    output T     rdata,
    output logic empty
);

    T           mem_reg [2];
    logic       wptr_reg;
    logic       wptr_next;
    logic       rptr_reg;
    logic       rptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       do_push;
    logic       do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg ^ do_push;
        rptr_next = rptr_reg ^ do_pop;
        cnt_next  = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/chit_front.sv =====
module chit_front
    import chit_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic [1:0]  opcode,
    input  logic [31:0] key_hash,
    input  logic [31:0] key_fingerprint,
    input  logic [31:0] entry_value,
    output logic        full,
    input  logic        req_pop,
    output req_t        req,
    output logic        req_valid
);

    req_t cls;
    logic q_empty;

    // Each request is classified once here so the engine only branches on kind.
    always_comb
    begin
        cls.key_hash        = key_hash;
        cls.key_fingerprint = key_fingerprint;
        cls.entry_value     = entry_value;
        unique case (opcode)
            OP_CLEAR:  cls.kind = KIND_CLEAR;
            OP_INSERT: cls.kind = KIND_INSERT;
            OP_FIND:   cls.kind = KIND_FIND;
            default:   cls.kind = KIND_NOP;
        endcase
    end

    chit_fifo #(.T(req_t)) u_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cls),
        .full  (full),
        .pop   (req_pop),
        .rdata (req),
        .empty (q_empty)
    );

    assign req_valid = !q_empty;

endmodule

// ===== rtl/chit_back.sv =====
module chit_back
    import chit_pkg::*;
#(
    parameter int MAX_ENTRIES    = DEF_MAX_ENTRIES,
    parameter int MAX_HEAD_SLOTS = DEF_MAX_HEAD_SLOTS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [11:0] table_length,
    input  req_t        req,
    input  logic        req_valid,
    output logic        req_pop,
    output res_t        res,
    output logic        res_push,
    input  logic        res_full,
    output logic        init_busy
);

    localparam int SW   = $clog2(MAX_HEAD_SLOTS);
    localparam int CNTW = $clog2(MAX_HEAD_SLOTS + 1);
    localparam int EW   = $clog2(MAX_ENTRIES);
    localparam int ECW  = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_HEAD,
        S_HEADCHK,
        S_ENT,
        S_ENTCHK,
        S_CLEAR,
        S_RESULT
    } state_t;

    state_t          state_reg;
    req_t            req_reg;
    logic [CNTW-1:0] rem_reg;
    logic [4:0]      bit_reg;
    logic [SW-1:0]   clr_reg;
    logic            init_reg;
    logic [ECW-1:0]  count_reg;
    logic [EW-1:0]   cur_reg;
    res_t            res_reg;

    logic [EW:0]     head_mem [MAX_HEAD_SLOTS];
    logic [EW:0]     next_mem [MAX_ENTRIES];
    logic [31:0]     fp_mem   [MAX_ENTRIES];
    logic [31:0]     val_mem  [MAX_ENTRIES];

    logic [EW:0]     head_rd;
    logic [EW:0]     next_rd;
    logic [31:0]     fp_rd;
    logic [31:0]     val_rd;

    logic            hd_we;
    logic [SW-1:0]   hd_wa;
    logic [EW:0]     hd_wd;
    logic            nx_we;
    logic [EW-1:0]   nx_wa;
    logic [EW:0]     nx_wd;
    logic            ent_we;

    logic [31:0]     tl_ext;
    logic [CNTW-1:0] n;
    logic [CNTW:0]   shifted;
    logic [SW-1:0]   slot;
    logic [EW-1:0]   new_idx;
    logic            is_insert;

    assign tl_ext    = 32'(table_length);
    assign slot      = rem_reg[SW-1:0];
    assign new_idx   = count_reg[EW-1:0];
    assign is_insert = (req_reg.kind == KIND_INSERT);
    assign shifted   = {rem_reg, req_reg.key_hash[bit_reg]};

    always_comb
    begin
        priority if (tl_ext == 32'd0)
            n = CNTW'(1);
        else if (tl_ext > 32'(MAX_HEAD_SLOTS))
            n = CNTW'(MAX_HEAD_SLOTS);
        else
            n = CNTW'(tl_ext);
    end

    assign req_pop   = req_valid && (state_reg == S_IDLE);
    assign res_push  = (state_reg == S_RESULT) && !res_full;
    assign res       = res_reg;
    assign init_busy = init_reg;

    always_comb
    begin
        hd_we  = 1'b0;
        hd_wa  = slot;
        hd_wd  = {1'b1, new_idx};
        nx_we  = 1'b0;
        nx_wa  = new_idx;
        nx_wd  = '0;
        ent_we = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                hd_we = 1'b1;
                hd_wa = clr_reg;
                hd_wd = '0;
            end
            S_HEADCHK:
            begin
                // Entry written as chain end; empty head links it now, else later.
                if (is_insert)
                begin
                    ent_we = 1'b1;
                    nx_we  = 1'b1;
                    hd_we  = !head_rd[EW];
                end
            end
            S_ENTCHK:
            begin
                if (is_insert && !next_rd[EW])
                begin
                    nx_we = 1'b1;
                    nx_wa = cur_reg;
                    nx_wd = {1'b1, new_idx};
                end
            end
            default:
            begin
                hd_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (hd_we)
        begin
            head_mem[hd_wa] <= hd_wd;
        end
        head_rd <= head_mem[slot];
    end

    always_ff @(posedge clk)
    begin
        if (nx_we)
        begin
            next_mem[nx_wa] <= nx_wd;
        end
        next_rd <= next_mem[cur_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            fp_mem[new_idx]  <= req_reg.key_fingerprint;
            val_mem[new_idx] <= req_reg.entry_value;
        end
        fp_rd  <= fp_mem[cur_reg];
        val_rd <= val_mem[cur_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            init_reg  <= 1'b1;
            count_reg <= '0;
            rem_reg   <= '0;
            bit_reg   <= '0;
            cur_reg   <= '0;
            res_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        req_reg <= req;
                        rem_reg <= '0;
                        bit_reg <= 5'd31;
                        clr_reg <= '0;
                        res_reg <= '{status: ST_MISS, found_value: 32'd0};
                        unique case (req.kind)
                            KIND_CLEAR:
                                state_reg <= S_CLEAR;
                            KIND_INSERT:
                            begin
                                if (count_reg == ECW'(MAX_ENTRIES))
                                begin
                                    res_reg   <= '{status: ST_FULL, found_value: 32'd0};
                                    state_reg <= S_RESULT;
                                end
                                else
                                begin
                                    state_reg <= S_MOD;
                                end
                            end
                            KIND_FIND:
                                state_reg <= S_MOD;
                            default:
                                state_reg <= S_RESULT;
                        endcase
                    end
                end
                S_MOD:
                begin
                    // Restoring division, one hash bit per cycle, MSB first.
                    if (shifted >= {1'b0, n})
                        rem_reg <= CNTW'(shifted - {1'b0, n});
                    else
                        rem_reg <= shifted[CNTW-1:0];
                    bit_reg <= bit_reg - 5'd1;
                    if (bit_reg == 5'd0)
                        state_reg <= S_HEAD;
                end
                S_HEAD:
                    state_reg <= S_HEADCHK;
                S_HEADCHK:
                begin
                    if (head_rd[EW])
                    begin
                        cur_reg   <= head_rd[EW-1:0];
                        state_reg <= S_ENT;
                    end
                    else
                    begin
                        if (is_insert)
                        begin
                            count_reg <= count_reg + ECW'(1);
                            res_reg   <= '{status: ST_OK, found_value: 32'd0};
                        end
                        state_reg <= S_RESULT;
                    end
                end
                S_ENT:
                    state_reg <= S_ENTCHK;
                S_ENTCHK:
                begin
                    priority if (!is_insert && fp_rd == req_reg.key_fingerprint)
                    begin
                        res_reg   <= '{status: ST_OK, found_value: val_rd};
                        state_reg <= S_RESULT;
                    end
                    else if (next_rd[EW])
                    begin
                        cur_reg   <= next_rd[EW-1:0];
                        state_reg <= S_ENT;
                    end
                    else
                    begin
                        if (is_insert)
                        begin
                            count_reg <= count_reg + ECW'(1);
                            res_reg   <= '{status: ST_OK, found_value: 32'd0};
                        end
                        state_reg <= S_RESULT;
                    end
                end
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + SW'(1);
                    if (clr_reg == SW'(MAX_HEAD_SLOTS - 1))
                    begin
                        count_reg <= '0;
                        if (init_reg)
                        begin
                            init_reg  <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            res_reg   <= '{status: ST_OK, found_value: 32'd0};
                            state_reg <= S_RESULT;
                        end
                    end
                end
                S_RESULT:
                begin
                    if (!res_full)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ECW'(MAX_ENTRIES))
        else $error("entry count exceeds capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg == $past(count_reg) || count_reg == $past(count_reg) + ECW'(1)
                  || count_reg == '0))
        else $error("entry count moved by more than one");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_HEAD |-> rem_reg < n)
        else $error("slot index not below slot count");

    a_full_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && res_reg.status == ST_FULL)
        |-> (is_insert && count_reg == ECW'(MAX_ENTRIES)))
        else $error("full status without a full table");

endmodule

// ===== rtl/chained_hash_index_table.sv =====
// Separately chained hash table addressed by a precomputed primary hash and
// fingerprint. Requests are queued in a two-entry front queue and results in
// a two-entry result queue, so each side can stall on its own. The engine
// handles one request at a time: insert and find take the request, reduce the
// hash modulo the slot count bit-serially (the dominant step for short chains),
// read the head slot, walk the chain one entry at a time, and hand off the
// result. An insert into a full store skips straight to handing off a full
// status. Clear sweeps the head-slot memory one slot a cycle over all
// MAX_HEAD_SLOTS slots, then hands off its result. After reset the same sweep
// runs with full held high; table_length may be written meanwhile.
module chained_hash_index_table
    import chit_pkg::*;
#(
    parameter int MAX_ENTRIES    = DEF_MAX_ENTRIES,
    parameter int MAX_HEAD_SLOTS = DEF_MAX_HEAD_SLOTS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  opcode,
    input  logic [31:0] key_hash,
    input  logic [31:0] key_fingerprint,
    input  logic [31:0] entry_value,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic [31:0] found_value
);

    logic [11:0] table_length_reg;
    logic        cfg_wr;
    logic        front_full;
    logic        init_busy;
    req_t        req;
    logic        req_valid;
    logic        req_pop;
    res_t        res;
    logic        res_push;
    logic        res_full;
    res_t        res_head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : 32'(table_length_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            table_length_reg <= TABLE_LENGTH_RST;
        else if (cfg_wr)
            table_length_reg <= pwdata[11:0];
    end

    assign full = front_full || init_busy;

    chit_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push && !full),
        .opcode          (opcode),
        .key_hash        (key_hash),
        .key_fingerprint (key_fingerprint),
        .entry_value     (entry_value),
        .full            (front_full),
        .req_pop         (req_pop),
        .req             (req),
        .req_valid       (req_valid)
    );

    chit_back #(
        .MAX_ENTRIES    (MAX_ENTRIES),
        .MAX_HEAD_SLOTS (MAX_HEAD_SLOTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .table_length (table_length_reg),
        .req          (req),
        .req_valid    (req_valid),
        .req_pop      (req_pop),
        .res          (res),
        .res_push     (res_push),
        .res_full     (res_full),
        .init_busy    (init_busy)
    );

    chit_fifo #(.T(res_t)) u_resq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_head),
        .empty (empty)
    );

    assign status      = res_head.status;
    assign found_value = res_head.found_value;

endmodule
